/* sv/assert_macros.svh */
// assertion macros used by lrq_core
// no dependencies; SYNTH removes the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property holds at every edge out of reset
`define LRQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lrq assertion failed");
// implication checked at every edge out of reset
`define LRQ_ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("lrq implication failed");
`else
`define LRQ_ASSERT(label, clk, rstn, prop)
`define LRQ_ASSERT_IMPL(label, clk, rstn, pre, post)
`endif
`endif

/* sv/lrq_pkg.sv */
// shared types and codes for the line row queue chunker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lrq_pkg;

    localparam logic [7:0] NEWLINE = 8'd10;
    localparam logic [2:0] ADDR_RESERVE = 3'd0;
    localparam logic [7:0] RESERVE_RESET = 8'd64;

    typedef enum logic [1:0] {
        KIND_TEXT    = 2'd0,
        KIND_SERVICE = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic        sink_ready;
        logic [15:0] sink_free;
    } in_t;

    typedef struct packed {
        logic        has_data;
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
        logic        row_done;
        logic [1:0]  rows_queued;
        logic        row_in_progress;
        logic [31:0] drop_total;
        logic [63:0] sent_total;
    } out_t;

endpackage
`default_nettype wire

/* sv/lrq_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4608
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* sv/lrq_core.sv */
// row builder, slot ring and chunk sequencer around the row memory
// depends on lrq_pkg, lrq_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lrq_core #(
    parameter int ROW_BYTES   = 1536,
    parameter int QUEUE_SLOTS = 2,
    parameter int CHUNK_BYTES = 192
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [7:0]    reserve_bytes,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lrq_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lrq_pkg::out_t      m_data
);
    import lrq_pkg::*;

    localparam int PHYS = QUEUE_SLOTS + 1;
    localparam int PW = $clog2(PHYS);
    localparam int SW = $clog2(QUEUE_SLOTS);
    localparam int QW = $clog2(QUEUE_SLOTS + 1);
    localparam int LW = $clog2(ROW_BYTES + 1);
    localparam int CW = $clog2(CHUNK_BYTES + 1);
    localparam int AW = $clog2(PHYS * ROW_BYTES);
    localparam int DW = $clog2(QUEUE_SLOTS + 2);

    state_t state_reg, state_next;

    logic [LW-1:0] blen_reg, blen_next;
    logic          ovf_reg, ovf_next;
    logic [PW-1:0] build_phys_reg, build_phys_next;
    logic [PW-1:0] slot_phys_reg [QUEUE_SLOTS];
    logic [LW-1:0] slot_len_reg [QUEUE_SLOTS];
    logic [SW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [QW-1:0] queued_reg, queued_next;
    logic [LW-1:0] offset_reg, offset_next;
    logic          sending_reg, sending_next;
    logic [31:0]   drop_reg, drop_next;
    logic [63:0]   total_reg, total_next;

    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] left_reg, left_next;
    logic [3:0]    n_reg, n_next, issue_reg, issue_next, cap_reg, cap_next;
    logic          pend_reg, pend_next, done_reg, done_next;
    logic [63:0]   word_reg, word_next;

    logic          m_valid_reg, m_valid_next;
    out_t          m_data_reg, m_data_next;

    logic          acc, out_free, close_ok, admit, wen, load_status, go_read;
    logic [SW-1:0] sel_idx;
    logic [PW-1:0] sel_phys;
    logic [LW-1:0] sel_len, off_now, remaining;
    logic [CW-1:0] chunk;
    logic [16:0]   need;
    logic [DW-1:0] drop_add;
    logic [32:0]   drop_sum;
    logic [AW-1:0] waddr;
    logic [7:0]    rdata;

    // row memory: QUEUE_SLOTS slots plus one build row, renamed on close
    lrq_ram #(.WIDTH(8), .DEPTH(PHYS * ROW_BYTES)) u_ram (
        .aclk  (aclk),
        .we    (wen),
        .waddr (waddr),
        .wdata (s_data.byte_value),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign acc      = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // slot lookup: tail on close, head on service
    assign sel_idx  = (s_data.kind == KIND_SERVICE) ? head_reg : tail_reg;
    assign sel_phys = slot_phys_reg[sel_idx];
    assign sel_len  = slot_len_reg[sel_idx];

    // chunk sizing and admission
    assign off_now   = sending_reg ? offset_reg : '0;
    assign remaining = (off_now < sel_len) ? sel_len - off_now : '0;
    assign chunk     = (remaining < LW'(CHUNK_BYTES)) ? CW'(remaining) : CW'(CHUNK_BYTES);
    assign need      = 17'(chunk) + 17'(reserve_bytes);
    assign admit     = (chunk != '0) && s_data.sink_ready && (17'(s_data.sink_free) >= need);

    assign wen   = acc && (s_data.kind == KIND_TEXT) && !ovf_reg
                   && (blen_reg < LW'(ROW_BYTES));
    assign waddr = AW'(build_phys_reg) * AW'(ROW_BYTES) + AW'(blen_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (go_read) state_next = ST_READ;
            ST_READ: if (pend_reg && (cap_reg + 4'd1 == n_reg)) state_next = ST_EMIT;
            ST_EMIT: if (out_free) state_next = (left_reg == CW'(n_reg)) ? ST_IDLE : ST_READ;
            default: state_next = ST_IDLE;
        endcase
    end

    // item handling, byte gathering and result register
    always_comb begin
        blen_next       = blen_reg;
        ovf_next        = ovf_reg;
        build_phys_next = build_phys_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        queued_next     = queued_reg;
        offset_next     = offset_reg;
        sending_next    = sending_reg;
        drop_next       = drop_reg;
        total_next      = total_reg;
        addr_next       = addr_reg;
        left_next       = left_reg;
        n_next          = n_reg;
        issue_next      = issue_reg;
        cap_next        = cap_reg;
        pend_next       = 1'b0;
        done_next       = done_reg;
        word_next       = word_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        drop_add        = '0;
        close_ok        = 1'b0;
        load_status     = 1'b0;
        go_read         = 1'b0;

        if (state_reg == ST_IDLE && acc) begin
            load_status = 1'b1;
            case (s_data.kind)
                KIND_TEXT: begin
                    if (!ovf_reg) begin
                        if (blen_reg < LW'(ROW_BYTES)) blen_next = blen_reg + 1'b1;
                        else ovf_next = 1'b1;
                    end
                    if (s_data.byte_value == NEWLINE) begin
                        close_ok = !ovf_next && (blen_next != '0)
                                   && (queued_reg != QW'(QUEUE_SLOTS));
                        if (close_ok) begin
                            build_phys_next = sel_phys;
                            tail_next = (tail_reg == SW'(QUEUE_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                            queued_next = queued_reg + 1'b1;
                        end else begin
                            drop_add = DW'(1);
                        end
                        blen_next = '0;
                        ovf_next  = 1'b0;
                    end
                end
                KIND_SERVICE: begin
                    if (sending_reg || queued_reg != '0) begin
                        sending_next = 1'b1;
                        offset_next  = off_now;
                        if (admit) begin
                            load_status = 1'b0;
                            go_read     = 1'b1;
                            addr_next   = AW'(sel_phys) * AW'(ROW_BYTES) + AW'(off_now);
                            left_next   = chunk;
                            n_next      = (chunk < CW'(8)) ? 4'(chunk) : 4'd8;
                            issue_next  = '0;
                            cap_next    = '0;
                            word_next   = '0;
                            total_next  = total_reg + 64'(chunk);
                            done_next   = (off_now + LW'(chunk) >= sel_len);
                            offset_next = off_now + LW'(chunk);
                            if (done_next) begin
                                sending_next = 1'b0;
                                offset_next  = '0;
                                head_next = (head_reg == SW'(QUEUE_SLOTS - 1)) ? '0
                                            : head_reg + 1'b1;
                                queued_next = queued_reg - 1'b1;
                            end
                        end
                    end
                end
                KIND_DISCARD: begin
                    drop_add = DW'(queued_reg) + DW'(blen_reg != '0 || ovf_reg);
                    queued_next  = '0;
                    blen_next    = '0;
                    ovf_next     = 1'b0;
                    head_next    = '0;
                    tail_next    = '0;
                    offset_next  = '0;
                    sending_next = 1'b0;
                end
                default: ;
            endcase
        end

        // saturating drop count
        drop_sum = 33'(drop_reg) + 33'(drop_add);
        if (drop_sum[32]) drop_next = '1;
        else drop_next = drop_sum[31:0];

        // streaming byte reads into the current word
        if (state_reg == ST_READ) begin
            if (issue_reg < n_reg) begin
                addr_next  = addr_reg + 1'b1;
                issue_next = issue_reg + 1'b1;
                pend_next  = 1'b1;
            end
            if (pend_reg) begin
                word_next[cap_reg[2:0]*8 +: 8] = rdata;
                cap_next = cap_reg + 1'b1;
            end
        end

        // hand a finished word to the result register
        if (state_reg == ST_EMIT && out_free) begin
            m_valid_next = 1'b1;
            m_data_next.has_data        = 1'b1;
            m_data_next.data_word       = word_reg;
            m_data_next.byte_count      = n_reg;
            m_data_next.last            = (left_reg == CW'(n_reg));
            m_data_next.row_done        = (left_reg == CW'(n_reg)) && done_reg;
            m_data_next.rows_queued     = 2'(queued_reg);
            m_data_next.row_in_progress = sending_reg;
            m_data_next.drop_total      = drop_reg;
            m_data_next.sent_total      = total_reg;
            left_next  = left_reg - CW'(n_reg);
            n_next     = (left_next < CW'(8)) ? 4'(left_next) : 4'd8;
            issue_next = '0;
            cap_next   = '0;
            word_next  = '0;
        end

        if (load_status) begin
            m_valid_next = 1'b1;
            m_data_next.has_data        = 1'b0;
            m_data_next.data_word       = '0;
            m_data_next.byte_count      = '0;
            m_data_next.last            = 1'b1;
            m_data_next.row_done        = 1'b0;
            m_data_next.rows_queued     = 2'(queued_next);
            m_data_next.row_in_progress = sending_next;
            m_data_next.drop_total      = drop_next;
            m_data_next.sent_total      = total_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            blen_reg       <= '0;
            ovf_reg        <= 1'b0;
            build_phys_reg <= PW'(QUEUE_SLOTS);
            head_reg       <= '0;
            tail_reg       <= '0;
            queued_reg     <= '0;
            offset_reg     <= '0;
            sending_reg    <= 1'b0;
            drop_reg       <= '0;
            total_reg      <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < QUEUE_SLOTS; i++) begin
                slot_phys_reg[i] <= PW'(i);
            end
        end else begin
            state_reg      <= state_next;
            blen_reg       <= blen_next;
            ovf_reg        <= ovf_next;
            build_phys_reg <= build_phys_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            queued_reg     <= queued_next;
            offset_reg     <= offset_next;
            sending_reg    <= sending_next;
            drop_reg       <= drop_next;
            total_reg      <= total_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
            if (close_ok) begin
                slot_phys_reg[tail_reg] <= build_phys_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        left_reg   <= left_next;
        n_reg      <= n_next;
        issue_reg  <= issue_next;
        cap_reg    <= cap_next;
        done_reg   <= done_next;
        word_reg   <= word_next;
        m_data_reg <= m_data_next;
        if (close_ok) begin
            slot_len_reg[tail_reg] <= blen_next == '0 ? blen_reg + LW'(!ovf_reg) : blen_reg + 1'b1;
        end
    end

    `LRQ_ASSERT(a_queue_bound, aclk, aresetn, queued_reg <= QW'(QUEUE_SLOTS))
    `LRQ_ASSERT_IMPL(a_busy_blocks_input, aclk, aresetn, state_reg != ST_IDLE, !s_ready)
    `LRQ_ASSERT_IMPL(a_drop_monotonic, aclk, aresetn, $past(aresetn), drop_reg >= $past(drop_reg))
    `LRQ_ASSERT_IMPL(a_build_not_queued, aclk, aresetn, queued_reg != '0,
                     build_phys_reg != slot_phys_reg[head_reg])
endmodule
`default_nettype wire

/* sv/line_row_queue_chunker.sv */
// top level: apb configuration register and the chunker core
// depends on lrq_pkg and lrq_core
`timescale 1ns / 1ps
`default_nettype none
// Text bytes (kind 0) are taken one per cycle while the result register drains and
// are written straight into the row memory; a finished row joins the slot ring by
// renaming, without a copy. A service item (kind 1) that admits a chunk reads the
// chunk one byte per cycle from the single read port of the row memory, pausing
// while a finished word waits for the result register, and sends it as words of
// up to 8 bytes: each word is gathered in the read state and handed over in the
// emit state, and no new input item is accepted until the whole chunk is sent.
// An input word is taken only while the result register is empty or is being
// drained in the same cycle, so a result waiting on m_ready holds off the input.
// reserve_bytes sits at byte address 0.
module line_row_queue_chunker #(
    parameter int ROW_BYTES   = 1536,
    parameter int QUEUE_SLOTS = 2,
    parameter int CHUNK_BYTES = 192
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lrq_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lrq_pkg::out_t      m_data
);
    import lrq_pkg::*;

    logic [7:0] reserve_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RESERVE) ? {24'd0, reserve_reg} : 32'd0;

    // reserve register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserve_reg <= RESERVE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_RESERVE) begin
            reserve_reg <= pwdata[7:0];
        end
    end

    lrq_core #(
        .ROW_BYTES   (ROW_BYTES),
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .reserve_bytes (reserve_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );
endmodule
`default_nettype wire

/* test/tb.sv */
// testbench for line_row_queue_chunker: random and directed items checked word by word
// against a predictor of the row queue; depends on lrq_pkg and line_row_queue_chunker
`timescale 1ns / 1ps
module tb;
    import lrq_pkg::*;

    localparam int ROW_MAX = 1536;
    localparam int CHUNK_MAX = 192;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    line_row_queue_chunker dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [7:0] build_bytes [ROW_MAX];
    int build_len = 0;
    bit build_ovf = 0;
    logic [7:0] slot_bytes [2][ROW_MAX];
    int slot_len [2];
    int head = 0;
    int tail = 0;
    int rows_held = 0;
    int send_pos = 0;
    bit row_open = 0;
    logic [31:0] drops = '0;
    logic [63:0] bytes_sent = '0;
    logic [7:0] reserve = RESERVE_RESET;

    in_t pending_items [$];
    out_t expected_words [$];
    int errors = 0;
    int sender_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    task automatic queue_word(bit data, logic [63:0] word, int cnt, bit fin, bit done);
        out_t w;
        w.has_data = data;
        w.data_word = word;
        w.byte_count = cnt[3:0];
        w.last = fin;
        w.row_done = done;
        w.rows_queued = rows_held[1:0];
        w.row_in_progress = row_open;
        w.drop_total = drops;
        w.sent_total = bytes_sent;
        expected_words.push_back(w);
    endtask

    function automatic void count_drop();
        if (drops != 32'hFFFF_FFFF) drops = drops + 1;
    endfunction

    // expected words for one accepted item
    task automatic chunk_predict(in_t it);
        int h, len, rem, chunk, base, n;
        logic [63:0] w;
        bit done;
        case (it.kind)
            KIND_TEXT: begin
                if (!build_ovf) begin
                    if (build_len < ROW_MAX) begin
                        build_bytes[build_len] = it.byte_value;
                        build_len++;
                    end else begin
                        build_ovf = 1;
                    end
                end
                if (it.byte_value == NEWLINE) begin
                    if (build_ovf || build_len == 0 || rows_held >= 2) begin
                        count_drop();
                    end else begin
                        for (int i = 0; i < build_len; i++) slot_bytes[tail][i] = build_bytes[i];
                        slot_len[tail] = build_len;
                        tail ^= 1;
                        rows_held++;
                    end
                    build_len = 0;
                    build_ovf = 0;
                end
            end
            KIND_SERVICE: begin
                if (!row_open) begin
                    if (rows_held == 0) begin
                        queue_word(0, '0, 0, 1, 0);
                        return;
                    end
                    send_pos = 0;
                    row_open = 1;
                end
                h = head;
                len = slot_len[h];
                rem = (send_pos < len) ? len - send_pos : 0;
                chunk = (rem < CHUNK_MAX) ? rem : CHUNK_MAX;
                if (chunk == 0 || !it.sink_ready || int'(it.sink_free) < chunk + int'(reserve)) begin
                    queue_word(0, '0, 0, 1, 0);
                    return;
                end
                base = send_pos;
                send_pos += chunk;
                bytes_sent = bytes_sent + 64'(chunk);
                done = (send_pos >= len);
                if (done) begin
                    row_open = 0;
                    send_pos = 0;
                    head ^= 1;
                    rows_held--;
                end
                for (int i = 0; i < chunk; i += 8) begin
                    n = (chunk - i < 8) ? chunk - i : 8;
                    w = '0;
                    for (int b = 0; b < n; b++) w[8*b +: 8] = slot_bytes[h][base + i + b];
                    queue_word(1, w, n, i + 8 >= chunk, (i + 8 >= chunk) && done);
                end
                return;
            end
            KIND_DISCARD: begin
                while (rows_held != 0) begin
                    count_drop();
                    rows_held--;
                end
                if (build_len != 0 || build_ovf) count_drop();
                build_len = 0;
                build_ovf = 0;
                head = 0;
                tail = 0;
                send_pos = 0;
                row_open = 0;
            end
            default: ;
        endcase
        queue_word(0, '0, 0, 1, 0);
    endtask

    // sender: offers pending words, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) chunk_predict(s_data);
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with random stalls and long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= 900;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor: compare each word with the oldest expectation
    always @(posedge aclk) begin
        out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word %h", m_data);
                errors++;
            end else begin
                e = expected_words.pop_front();
                check_field("has_data", e.has_data, m_data.has_data);
                check_field("data_word", e.data_word, m_data.data_word);
                check_field("byte_count", e.byte_count, m_data.byte_count);
                check_field("last", e.last, m_data.last);
                check_field("row_done", e.row_done, m_data.row_done);
                check_field("rows_queued", e.rows_queued, m_data.rows_queued);
                check_field("row_in_progress", e.row_in_progress, m_data.row_in_progress);
                check_field("drop_total", e.drop_total, m_data.drop_total);
                check_field("sent_total", e.sent_total, m_data.sent_total);
            end
        end
    end

    function automatic in_t make_item(logic [1:0] k, logic [7:0] b, logic r, logic [15:0] f);
        in_t it;
        it.kind = k;
        it.byte_value = b;
        it.sink_ready = r;
        it.sink_free = f;
        return it;
    endfunction

    function automatic void add_text(logic [7:0] b);
        pending_items.push_back(make_item(KIND_TEXT, b, 1'($urandom), 16'($urandom)));
    endfunction

    function automatic void add_service(logic r, logic [15:0] f);
        pending_items.push_back(make_item(KIND_SERVICE, 8'($urandom), r, f));
    endfunction

    function automatic void add_row(int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (b == NEWLINE) b = 8'h0B;
            add_text(b);
        end
        add_text(NEWLINE);
    endfunction

    // mostly well-formed rows and services, some noise
    function automatic void add_random(int n);
        int start;
        int pick;
        start = pending_items.size();
        while (pending_items.size() - start < n) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                add_row(($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12));
            end else if (pick < 80) begin
                add_service($urandom_range(9) != 0,
                            ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300, 65535)));
            end else if (pick < 88) begin
                add_text(8'($urandom));
            end else if (pick < 94) begin
                pending_items.push_back(make_item(KIND_DISCARD, 8'($urandom), 1'($urandom),
                                                  16'($urandom)));
            end else begin
                pending_items.push_back(make_item(KIND_UNUSED, 8'($urandom), 1'($urandom),
                                                  16'($urandom)));
            end
        end
    endfunction

    // wait until every pending item is sent, every expected word has come and the block settles
    task automatic drain();
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_words.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reserve_write(logic [7:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_RESERVE;
        pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reserve = value;
    endtask

    // run limit
    initial begin
        #30ms;
        $display("[line_row_queue_chunker] ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every kind, admission edges, full ring
        add_service(1, 16'hFFFF);
        add_text(8'h00);
        add_text(8'hFF);
        add_text(NEWLINE);
        add_text(NEWLINE);
        add_service(0, 16'hFFFF);
        add_service(1, 16'd65);
        add_service(1, 16'd67);
        add_row(3);
        add_row(9);
        add_row(5);
        add_service(1, 16'hFFFF);
        add_service(1, 16'hFFFF);
        add_service(1, 16'h0000);
        add_service(1, 16'hFFFF);
        pending_items.push_back(make_item(KIND_UNUSED, 8'hFF, 1'b1, 16'hFFFF));
        add_row(2);
        add_text(8'h41);
        pending_items.push_back(make_item(KIND_DISCARD, 8'h00, 1'b0, 16'h0000));
        add_row(12);
        add_service(1, 16'hFFFF);
        drain();

        reserve_write(8'd0);
        add_row(7);
        add_service(1, 16'd7);
        add_service(1, 16'd8);
        add_random(10);
        drain();

        // long receiver hold-off while the sender keeps going
        reserve_write(8'd255);
        hold_requests++;
        for (int i = 0; i < 3; i++) begin
            add_row(4);
            add_service(1, 16'hFFFF);
        end
        add_random(8);
        drain();

        reserve_write(8'($urandom));
        sender_idle_pct = 52;
        add_random(17);
        drain();

        sender_idle_pct = 0;
        sink_stall_pct = 52;
        reserve_write(8'($urandom_range(0, 100)));
        add_random(17);
        drain();

        sender_idle_pct = 24;
        sink_stall_pct = 24;
        reserve_write(RESERVE_RESET);
        add_random(17);
        drain();

        if (errors == 0) begin
            $display("[line_row_queue_chunker] OK");
        end else begin
            $display("[line_row_queue_chunker] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/lrq_pkg.sv
sv/lrq_ram.sv
sv/lrq_core.sv
sv/line_row_queue_chunker.sv
test/tb.sv
